@@ sv/sms_pkg.sv @@
// ----------------------------------------------------------------------------
// Slider motion supervisor package
// Shared types, codes and constants for the slider axis supervisor.
// ----------------------------------------------------------------------------
package sms_pkg;

    // Field widths.
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STEPS_W  = 32;
    localparam int unsigned SPEED_W  = 20;
    localparam int unsigned RAIL_W   = 31;
    localparam int unsigned REPLY_W  = 2;
    localparam int unsigned MCODE_W  = 3;
    localparam int unsigned STOP_W   = 2;
    localparam int unsigned CIDX_W   = 2;
    localparam int unsigned CDATA_W  = 31;

    // Command codes of an input beat.
    localparam logic [CMD_W-1:0] CMD_TICK      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_HOME      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_STOP      = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CONFIGURE = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DONE      = 3'd5;

    // Reply codes.
    localparam logic [REPLY_W-1:0] REPLY_OK      = 2'd0;
    localparam logic [REPLY_W-1:0] REPLY_BUSY    = 2'd1;
    localparam logic [REPLY_W-1:0] REPLY_INVALID = 2'd2;
    localparam logic [REPLY_W-1:0] REPLY_BOUNDS  = 2'd3;

    // Reported mode codes.
    localparam logic [MCODE_W-1:0] MCODE_IDLE        = 3'd0;
    localparam logic [MCODE_W-1:0] MCODE_HOMING      = 3'd1;
    localparam logic [MCODE_W-1:0] MCODE_MOVING      = 3'd2;
    localparam logic [MCODE_W-1:0] MCODE_CONFIGURING = 3'd3;
    localparam logic [MCODE_W-1:0] MCODE_ERROR       = 3'd4;

    // Stop command codes.
    localparam logic [STOP_W-1:0] STOP_NONE = 2'd0;
    localparam logic [STOP_W-1:0] STOP_SOFT = 2'd1;
    localparam logic [STOP_W-1:0] STOP_HOME = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] REG_RAIL_LENGTH  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_HOME_SPEED   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ACCELERATION = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [RAIL_W-1:0]  RAIL_LENGTH_RST  = 31'd100000;
    localparam logic [SPEED_W-1:0] HOME_SPEED_RST   = 20'd1000;
    localparam logic [SPEED_W-1:0] ACCELERATION_RST = 20'd1000;

    // Step count issued with the homing move.
    localparam logic signed [STEPS_W-1:0] HOME_STEPS = -32'sd100000;

    typedef enum logic [3:0] {
        MODE_IDLE        = 4'b0001,
        MODE_HOMING      = 4'b0010,
        MODE_MOVING      = 4'b0100,
        MODE_CONFIGURING = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [RAIL_W-1:0]  rail_length;
        logic [SPEED_W-1:0] home_speed;
        logic [SPEED_W-1:0] acceleration;
    } cfg_t;

    typedef struct packed {
        mode_t                      mode;
        logic                       homed;
        logic                       configured;
        logic signed [STEPS_W-1:0]  held_steps;
        logic [SPEED_W-1:0]         held_speed;
        logic                       home_pending;
        logic                       move_pending;
        logic                       stop_pending;
        logic                       config_pending;
        logic                       done;
    } state_t;

    typedef struct packed {
        logic [CMD_W-1:0]           command;
        logic signed [STEPS_W-1:0]  req_steps;
        logic [SPEED_W-1:0]         req_speed;
        logic signed [STEPS_W-1:0]  current_position;
        logic                       end_switch_hit;
    } req_t;

    typedef struct packed {
        logic [REPLY_W-1:0]         reply;
        logic [MCODE_W-1:0]         mode;
        logic                       fault_code;
        logic                       is_homed;
        logic                       is_configured;
        logic                       start_move;
        logic signed [STEPS_W-1:0]  move_steps;
        logic [SPEED_W-1:0]         move_speed;
        logic [SPEED_W-1:0]         move_accel;
        logic [STOP_W-1:0]          stop_motor;
        logic                       zero_position;
    } result_t;

    function automatic logic [MCODE_W-1:0] mode_code(input mode_t m);
        logic [MCODE_W-1:0] code;
        unique case (m)
            MODE_IDLE:        code = MCODE_IDLE;
            MODE_HOMING:      code = MCODE_HOMING;
            MODE_MOVING:      code = MCODE_MOVING;
            MODE_CONFIGURING: code = MCODE_CONFIGURING;
            default:          code = MCODE_ERROR;
        endcase
        return code;
    endfunction

endpackage

@@ sv/sms_if.sv @@
// ----------------------------------------------------------------------------
// Slider motion supervisor channels
// Valid/ready channels for requests, results and register writes.
// ----------------------------------------------------------------------------
interface sms_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [sms_pkg::CMD_W-1:0]              command;
    logic signed [sms_pkg::STEPS_W-1:0]     req_steps;
    logic [sms_pkg::SPEED_W-1:0]            req_speed;
    logic signed [sms_pkg::STEPS_W-1:0]     current_position;
    logic                                   end_switch_hit;

    modport source (output valid, command, req_steps, req_speed, current_position,
                    end_switch_hit, input ready);
    modport sink   (input valid, command, req_steps, req_speed, current_position,
                    end_switch_hit, output ready);
endinterface

interface sms_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic [sms_pkg::REPLY_W-1:0]            reply;
    logic [sms_pkg::MCODE_W-1:0]            mode;
    logic                                   fault_code;
    logic                                   is_homed;
    logic                                   is_configured;
    logic                                   start_move;
    logic signed [sms_pkg::STEPS_W-1:0]     move_steps;
    logic [sms_pkg::SPEED_W-1:0]            move_speed;
    logic [sms_pkg::SPEED_W-1:0]            move_accel;
    logic [sms_pkg::STOP_W-1:0]             stop_motor;
    logic                                   zero_position;

    modport source (output valid, reply, mode, fault_code, is_homed, is_configured,
                    start_move, move_steps, move_speed, move_accel, stop_motor,
                    zero_position, input ready);
    modport sink   (input valid, reply, mode, fault_code, is_homed, is_configured,
                    start_move, move_steps, move_speed, move_accel, stop_motor,
                    zero_position, output ready);
endinterface

interface sms_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [sms_pkg::CIDX_W-1:0]         index;
    logic [sms_pkg::CDATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/sms_core.sv @@
// ----------------------------------------------------------------------------
// Slider motion supervisor decision logic
// Validates one request beat and works out the next state and the result.
// ----------------------------------------------------------------------------
module sms_core (
    input  sms_pkg::state_t  state,
    input  sms_pkg::cfg_t    cfg,
    input  sms_pkg::req_t    req,
    output sms_pkg::state_t  state_next,
    output sms_pkg::result_t result
);
    import sms_pkg::*;

    logic signed [STEPS_W:0] target;
    logic                    out_of_bounds;

    // Exact target position; once the axis is homed, a negative one or one past the rail is rejected.
    assign target = {req.current_position[STEPS_W-1], req.current_position}
                  + {req.req_steps[STEPS_W-1], req.req_steps};
    assign out_of_bounds = target[STEPS_W]
                        || (target[STEPS_W-1:0] > {1'b0, cfg.rail_length});

    always_comb
    begin
        state_next = state;
        result     = '0;
        result.reply = REPLY_OK;

        unique case (req.command)
            CMD_TICK:
            begin
                if (state.stop_pending)
                begin
                    state_next.stop_pending = 1'b0;
                    if (state.mode == MODE_MOVING || state.mode == MODE_HOMING)
                    begin
                        result.stop_motor = STOP_SOFT;
                    end
                end
                unique case (state.mode)
                    MODE_IDLE:
                    begin
                        priority if (state.home_pending)
                        begin
                            state_next.home_pending = 1'b0;
                            state_next.mode         = MODE_HOMING;
                            state_next.homed        = 1'b0;
                            state_next.done         = 1'b0;
                            result.start_move       = 1'b1;
                            result.move_steps       = HOME_STEPS;
                            result.move_speed       = cfg.home_speed;
                            result.move_accel       = cfg.acceleration;
                        end
                        else if (state.config_pending)
                        begin
                            state_next.config_pending = 1'b0;
                            state_next.mode           = MODE_CONFIGURING;
                        end
                        else if (state.move_pending)
                        begin
                            state_next.move_pending = 1'b0;
                            state_next.mode         = MODE_MOVING;
                            state_next.done         = 1'b0;
                            result.start_move       = 1'b1;
                            result.move_steps       = state.held_steps;
                            result.move_speed       = state.held_speed;
                            result.move_accel       = cfg.acceleration;
                        end
                    end
                    MODE_CONFIGURING:
                    begin
                        state_next.configured = 1'b1;
                        state_next.mode       = MODE_IDLE;
                    end
                    MODE_HOMING:
                    begin
                        if (state.done || req.end_switch_hit)
                        begin
                            result.stop_motor    = STOP_HOME;
                            result.zero_position = 1'b1;
                            state_next.homed     = 1'b1;
                            state_next.done      = 1'b1;
                            state_next.mode      = MODE_IDLE;
                        end
                    end
                    MODE_MOVING:
                    begin
                        if (state.done)
                        begin
                            state_next.done = 1'b0;
                            state_next.mode = MODE_IDLE;
                        end
                    end
                    default:
                    begin
                        state_next.mode = state.mode;
                    end
                endcase
            end
            CMD_HOME:
            begin
                if (state.mode != MODE_IDLE)
                begin
                    result.reply = REPLY_BUSY;
                end
                else
                begin
                    state_next.home_pending = 1'b1;
                end
            end
            CMD_MOVE:
            begin
                priority if (req.req_steps == '0 || req.req_speed == '0)
                begin
                    result.reply = REPLY_INVALID;
                end
                else if (state.mode != MODE_IDLE)
                begin
                    result.reply = REPLY_BUSY;
                end
                else if (state.homed && out_of_bounds)
                begin
                    result.reply = REPLY_BOUNDS;
                end
                else
                begin
                    state_next.held_steps   = req.req_steps;
                    state_next.held_speed   = req.req_speed;
                    state_next.move_pending = 1'b1;
                end
            end
            CMD_STOP:
            begin
                state_next.stop_pending = 1'b1;
            end
            CMD_CONFIGURE:
            begin
                if (state.mode != MODE_IDLE)
                begin
                    result.reply = REPLY_BUSY;
                end
                else
                begin
                    state_next.config_pending = 1'b1;
                end
            end
            CMD_DONE:
            begin
                state_next.done = 1'b1;
            end
            default:
            begin
                result.reply = REPLY_OK;
            end
        endcase

        result.mode          = mode_code(state_next.mode);
        result.fault_code    = 1'b0;
        result.is_homed      = state_next.homed;
        result.is_configured = state_next.configured;
    end

endmodule

@@ sv/slider_motion_supervisor.sv @@
// ----------------------------------------------------------------------------
// Slider motion supervisor
// Validates axis requests, serves them on scheduler ticks and issues stepper
// commands, one result beat per request beat.
// ----------------------------------------------------------------------------
//
//  Channel  Role   Carries
//  -------  -----  -----------------------------------------------------------
//  req      sink   one event per beat: tick, home, move, stop, configure, done
//  rsp      source one result per request beat: reply, mode, flags, commands
//  cfg      sink   register writes: rail_length, home_speed, acceleration
//
// Every request beat is decided in the cycle it is accepted and its result is
// registered, so the result appears in the cycle after acceptance.
// The block takes one beat per cycle; the only limit is the result register,
// which accepts a new beat whenever it is empty or being drained.
// A stall on rsp holds the result and drops req.ready until it is taken.
// Reset clears the axis state and loads the register defaults; cfg is always
// ready and a write takes effect from the next cycle.
//
module slider_motion_supervisor #(
    parameter logic [sms_pkg::RAIL_W-1:0]  RailLengthRst  = sms_pkg::RAIL_LENGTH_RST,
    parameter logic [sms_pkg::SPEED_W-1:0] HomeSpeedRst   = sms_pkg::HOME_SPEED_RST,
    parameter logic [sms_pkg::SPEED_W-1:0] AccelerationRst = sms_pkg::ACCELERATION_RST
) (
    input  logic       clk,
    input  logic       rst_n,
    sms_req_if.sink    req,
    sms_rsp_if.source  rsp,
    sms_cfg_if.sink    cfg
);
    import sms_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    cfg_t    cfg_reg;
    req_t    req_beat;
    result_t result_reg;
    result_t result_next;
    logic    rsp_valid_reg;
    logic    req_fire;

    // The request beat is gathered into one word for the decision logic.
    assign req_beat.command          = req.command;
    assign req_beat.req_steps        = req.req_steps;
    assign req_beat.req_speed        = req.req_speed;
    assign req_beat.current_position = req.current_position;
    assign req_beat.end_switch_hit   = req.end_switch_hit;

    // A new beat is taken whenever the result register is free this cycle.
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign req_fire  = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    sms_core u_core (
        .state      (state_reg),
        .cfg        (cfg_reg),
        .req        (req_beat),
        .state_next (state_next),
        .result     (result_next)
    );

    // Axis state advances only on an accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg                <= '{mode: MODE_IDLE, default: '0};
            rsp_valid_reg            <= 1'b0;
        end
        else
        begin
            if (req_fire)
            begin
                state_reg     <= state_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is qualified by rsp_valid_reg.
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            result_reg <= result_next;
        end
    end

    // Register writes. An index past the last register is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rail_length  <= RailLengthRst;
            cfg_reg.home_speed   <= HomeSpeedRst;
            cfg_reg.acceleration <= AccelerationRst;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_RAIL_LENGTH:  cfg_reg.rail_length  <= cfg.data[RAIL_W-1:0];
                REG_HOME_SPEED:   cfg_reg.home_speed   <= cfg.data[SPEED_W-1:0];
                REG_ACCELERATION: cfg_reg.acceleration <= cfg.data[SPEED_W-1:0];
                default:          cfg_reg.rail_length  <= cfg_reg.rail_length;
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.reply         = result_reg.reply;
    assign rsp.mode          = result_reg.mode;
    assign rsp.fault_code    = result_reg.fault_code;
    assign rsp.is_homed      = result_reg.is_homed;
    assign rsp.is_configured = result_reg.is_configured;
    assign rsp.start_move    = result_reg.start_move;
    assign rsp.move_steps    = result_reg.move_steps;
    assign rsp.move_speed    = result_reg.move_speed;
    assign rsp.move_accel    = result_reg.move_accel;
    assign rsp.stop_motor    = result_reg.stop_motor;
    assign rsp.zero_position = result_reg.zero_position;

    // A move or homing only starts from idle, where no stop can be issued.
    a_start_without_stop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && result_reg.start_move |-> result_reg.stop_motor == STOP_NONE)
        else $error("start-move issued together with a stop");

    // Zeroing the position only happens at the end of homing.
    a_zero_ends_homing: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && result_reg.zero_position |->
            result_reg.stop_motor == STOP_HOME && result_reg.is_homed
            && result_reg.mode == MCODE_IDLE)
        else $error("position zeroed outside the end of homing");

    // Only a tick moves the state machine.
    a_mode_on_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && req.command != CMD_TICK |=> state_reg.mode == $past(state_reg.mode))
        else $error("mode changed on a beat that is not a tick");

    // A beat is never accepted while a result is held back by a stall.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp.ready |-> !req_fire)
        else $error("request accepted over a stalled result");

endmodule
